// ----- rtl/xrec_pkg.sv -----
// Shared types, constants and character helpers for the XML root element classifier.
// No dependencies; every other file refers to it by scoped names.
package xrec_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned NAME_LEN_W = 5;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned NUM_ROOTS  = 4;

  localparam logic [LIMIT_W-1:0]    PEEK_MAX     = 13'd4096;
  localparam logic [NAME_LEN_W-1:0] MAX_NAME_LEN = 5'd31;

  localparam logic [KIND_W-1:0] KIND_NONE        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PORTFOLIO   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CURRENCY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CALENDAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONVENTIONS = 3'd4;

  localparam logic [DATA_W-1:0] CH_LT    = 8'h3C;  // <
  localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;  // >
  localparam logic [DATA_W-1:0] CH_BANG  = 8'h21;  // !
  localparam logic [DATA_W-1:0] CH_QUEST = 8'h3F;  // ?
  localparam logic [DATA_W-1:0] CH_DASH  = 8'h2D;  // -
  localparam logic [DATA_W-1:0] CH_UNDER = 8'h5F;  // _
  localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;  // :

  localparam logic [NAME_LEN_W-1:0] LEN_PORTFOLIO   = 5'd9;
  localparam logic [NAME_LEN_W-1:0] LEN_CURRENCY    = 5'd14;
  localparam logic [NAME_LEN_W-1:0] LEN_CALENDAR    = 5'd19;
  localparam logic [NAME_LEN_W-1:0] LEN_CONVENTIONS = 5'd11;

  localparam logic [8*9-1:0]  STR_PORTFOLIO   = "Portfolio";
  localparam logic [8*14-1:0] STR_CURRENCY    = "CurrencyConfig";
  localparam logic [8*19-1:0] STR_CALENDAR    = "CalendarAdjustments";
  localparam logic [8*11-1:0] STR_CONVENTIONS = "Conventions";

  typedef struct packed {
    logic                  emit;
    logic [KIND_W-1:0]     kind;
    logic [NAME_LEN_W-1:0] len;
  } xrec_result_t;

  function automatic logic is_name_char(input logic [DATA_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c == CH_UNDER) || (c == CH_COLON);
  endfunction

  // Character idx of fixed root name k, or zero past its end.
  function automatic logic [DATA_W-1:0] root_char(input logic [1:0] k,
                                                  input logic [NAME_LEN_W-1:0] idx);
    logic [DATA_W-1:0] ch;
    int unsigned       pos;
    ch  = 8'h00;
    pos = int'(idx);
    case (k)
      2'd0: if (idx < LEN_PORTFOLIO) ch = STR_PORTFOLIO[8*(8-pos) +: 8];
      2'd1: if (idx < LEN_CURRENCY) ch = STR_CURRENCY[8*(13-pos) +: 8];
      2'd2: if (idx < LEN_CALENDAR) ch = STR_CALENDAR[8*(18-pos) +: 8];
      2'd3: if (idx < LEN_CONVENTIONS) ch = STR_CONVENTIONS[8*(10-pos) +: 8];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [KIND_W-1:0] root_kind(input logic [NUM_ROOTS-1:0] flags,
                                                  input logic [NAME_LEN_W-1:0] chars);
    logic [KIND_W-1:0] kind;
    kind = KIND_NONE;
    if (flags[0] && chars == LEN_PORTFOLIO)   kind = KIND_PORTFOLIO;
    if (flags[1] && chars == LEN_CURRENCY)    kind = KIND_CURRENCY;
    if (flags[2] && chars == LEN_CALENDAR)    kind = KIND_CALENDAR;
    if (flags[3] && chars == LEN_CONVENTIONS) kind = KIND_CONVENTIONS;
    return kind;
  endfunction

endpackage

// ----- rtl/xrec_match.sv -----
// Root name matcher: folds one name character into the candidate flags and length.
// Depends on xrec_pkg.
module xrec_match (
  input  logic [xrec_pkg::DATA_W-1:0]     ch_i,
  input  logic [xrec_pkg::NAME_LEN_W-1:0] chars_i,
  input  logic [xrec_pkg::NUM_ROOTS-1:0]  flags_i,
  output logic [xrec_pkg::NAME_LEN_W-1:0] chars_o,
  output logic [xrec_pkg::NUM_ROOTS-1:0]  flags_o
);

  // A flag survives only while the name is still a prefix of that root.
  always_comb begin
    for (int k = 0; k < xrec_pkg::NUM_ROOTS; k++) begin
      flags_o[k] = flags_i[k] && (ch_i == xrec_pkg::root_char(2'(k), chars_i));
    end
  end

  assign chars_o = (chars_i < xrec_pkg::MAX_NAME_LEN) ? chars_i + 5'd1 : chars_i;

endmodule

// ----- rtl/xrec_scan.sv -----
// Scanner state machine: skips comments and declarations, tracks the root name.
// Depends on xrec_pkg and xrec_match.
module xrec_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [xrec_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            last_i,
  input  logic [xrec_pkg::LIMIT_W-1:0]    peek_limit_i,
  output xrec_pkg::xrec_result_t          res_o
);

  typedef enum logic [2:0] {
    ST_SEEK,
    ST_TAG,
    ST_BANG,
    ST_BANG_DASH,
    ST_COMMENT,
    ST_DECL,
    ST_NAME,
    ST_DONE
  } mode_e;

  mode_e                            mode_q, mode_d;
  logic [1:0]                       dash_q, dash_d;
  logic [xrec_pkg::LIMIT_W-1:0]     seen_q, seen_d;
  logic [xrec_pkg::NAME_LEN_W-1:0]  chars_q, chars_d, chars_take;
  logic [xrec_pkg::NUM_ROOTS-1:0]   flags_q, flags_d, flags_take;
  logic [xrec_pkg::LIMIT_W-1:0]     lim;
  logic                             active;
  logic                             name_ch;

  xrec_match u_match (
    .ch_i    (data_byte_i),
    .chars_i (chars_q),
    .flags_i (flags_q),
    .chars_o (chars_take),
    .flags_o (flags_take)
  );

  assign lim     = (peek_limit_i > xrec_pkg::PEEK_MAX) ? xrec_pkg::PEEK_MAX : peek_limit_i;
  assign active  = step_i && (seen_q < lim) && (mode_q != ST_DONE);
  assign name_ch = xrec_pkg::is_name_char(data_byte_i);

  always_comb begin
    mode_d    = mode_q;
    dash_d    = dash_q;
    seen_d    = seen_q;
    chars_d   = chars_q;
    flags_d   = flags_q;
    res_o     = '0;
    if (active) begin
      seen_d = seen_q + 13'd1;
      case (mode_q)
        ST_SEEK: begin
          if (data_byte_i == xrec_pkg::CH_LT) mode_d = ST_TAG;
        end
        ST_TAG: begin
          if (data_byte_i == xrec_pkg::CH_BANG) begin
            mode_d = ST_BANG;
          end else if (data_byte_i == xrec_pkg::CH_QUEST) begin
            mode_d = ST_DECL;
          end else if (name_ch) begin
            chars_d = chars_take;
            flags_d = flags_take;
            mode_d  = ST_NAME;
          end else begin
            mode_d = ST_DONE;  // empty root name
          end
        end
        ST_BANG, ST_BANG_DASH: begin
          if (data_byte_i == xrec_pkg::CH_DASH) begin
            if (mode_q == ST_BANG) begin
              mode_d = ST_BANG_DASH;
            end else begin
              mode_d = ST_COMMENT;
              dash_d = 2'd0;
            end
          end else if (data_byte_i == xrec_pkg::CH_GT) begin
            mode_d = ST_SEEK;
          end else begin
            mode_d = ST_DECL;
          end
        end
        ST_COMMENT: begin
          if (data_byte_i == xrec_pkg::CH_DASH) begin
            if (dash_q < 2'd2) dash_d = dash_q + 2'd1;
          end else begin
            if (data_byte_i == xrec_pkg::CH_GT && dash_q == 2'd2) mode_d = ST_SEEK;
            dash_d = 2'd0;
          end
        end
        ST_DECL: begin
          if (data_byte_i == xrec_pkg::CH_GT) mode_d = ST_SEEK;
        end
        ST_NAME: begin
          if (name_ch) begin
            chars_d = chars_take;
            flags_d = flags_take;
          end else begin
            res_o.emit = 1'b1;
            res_o.kind = xrec_pkg::root_kind(flags_q, chars_q);
            res_o.len  = chars_q;
            mode_d     = ST_DONE;
          end
        end
        default: mode_d = mode_q;
      endcase
      // name cut short by the last byte or the peek limit
      if (!res_o.emit && mode_d == ST_NAME && (last_i || seen_d >= lim)) begin
        res_o.emit = 1'b1;
        res_o.kind = xrec_pkg::root_kind(flags_d, chars_d);
        res_o.len  = chars_d;
        mode_d     = ST_DONE;
      end
    end
    if (step_i && last_i) begin
      mode_d  = ST_SEEK;
      dash_d  = 2'd0;
      seen_d  = '0;
      chars_d = '0;
      flags_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ST_SEEK;
      dash_q  <= 2'd0;
      seen_q  <= '0;
      chars_q <= '0;
      flags_q <= '1;
    end else begin
      mode_q  <= mode_d;
      dash_q  <= dash_d;
      seen_q  <= seen_d;
      chars_q <= chars_d;
      flags_q <= flags_d;
    end
  end

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= xrec_pkg::PEEK_MAX)
    else $error("byte count ran past the peek maximum");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.emit && !last_i) |=> (mode_q == ST_DONE))
    else $error("scanner kept going after giving a word");

  a_name_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ST_NAME) |-> (chars_q != '0))
    else $error("name state with no characters");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (mode_q == ST_SEEK && seen_q == '0 && flags_q == '1))
    else $error("state not cleared after last byte");

endmodule

// ----- rtl/xml_root_element_classifier_unit.sv -----
// XML root element classifier, top level: input word register, scanner, result register.
// Depends on xrec_pkg and xrec_scan.
//
// Usage: a document enters as bytes on the in channel (data_byte_i, last_i marks the
// final byte), valid/ready handshake. The cfg channel writes peek_limit (13 bits,
// reset 4096, values above 4096 act as 4096); cfg_ready_o is always high and writes
// belong between documents.
// The out channel gives at most one word per document: kind_o (0 none,
// 1 Portfolio, 2 CurrencyConfig, 3 CalendarAdjustments, 4 Conventions) and
// root_length_o (root name length, saturating at 31).
// An accepted byte waits in the input register until the scanner steps on it; its word,
// if any, is then loaded into the result register and shows on out_valid_o.
// Throughput: one byte per cycle; the scanner does one state step per byte, so the
// input register drains every cycle that the result register can load.
// A stalled receiver holds the result register; the input register keeps one more
// byte, and in_ready_o drops only while both are full and out_ready_i is low.
// Reset clears the scanner, both valid flags and sets peek_limit to 4096. After the
// last byte of a document the scanner returns to its reset state.
module xml_root_element_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [xrec_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            last_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [xrec_pkg::LIMIT_W-1:0]    cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [xrec_pkg::KIND_W-1:0]     kind_o,
  output logic [xrec_pkg::NAME_LEN_W-1:0] root_length_o
);

  logic                             in_vld_q;
  logic [xrec_pkg::DATA_W-1:0]      byte_q;
  logic                             last_q;
  logic [xrec_pkg::LIMIT_W-1:0]     limit_q;
  logic                             out_vld_q, out_vld_d;
  logic [xrec_pkg::KIND_W-1:0]      kind_q;
  logic [xrec_pkg::NAME_LEN_W-1:0]  len_q;
  logic                             step;
  xrec_pkg::xrec_result_t           res;

  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;

  xrec_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (byte_q),
    .last_i       (last_q),
    .peek_limit_i (limit_q),
    .res_o        (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (step && res.emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      limit_q   <= xrec_pkg::PEEK_MAX;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_i;
    end
    if (step && res.emit) begin
      kind_q <= res.kind;
      len_q  <= res.len;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = kind_q;
  assign root_length_o = len_q;

  a_kind_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == xrec_pkg::KIND_NONE) ||
                     (kind_o == xrec_pkg::KIND_PORTFOLIO &&
                      root_length_o == xrec_pkg::LEN_PORTFOLIO) ||
                     (kind_o == xrec_pkg::KIND_CURRENCY &&
                      root_length_o == xrec_pkg::LEN_CURRENCY) ||
                     (kind_o == xrec_pkg::KIND_CALENDAR &&
                      root_length_o == xrec_pkg::LEN_CALENDAR) ||
                     (kind_o == xrec_pkg::KIND_CONVENTIONS &&
                      root_length_o == xrec_pkg::LEN_CONVENTIONS)))
    else $error("kind does not agree with root length");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_length_o != '0))
    else $error("word given for an empty root name");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.emit) |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten while held");

  a_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> (in_vld_q && $stable(byte_q) && $stable(last_q)))
    else $error("waiting input word was lost");

endmodule
